[rtl/queue_with_middle_insert_core_macros.svh]
// assertion macros for the queue with middle insert
`ifndef QUEUE_WITH_MIDDLE_INSERT_CORE_MACROS_SVH
`define QUEUE_WITH_MIDDLE_INSERT_CORE_MACROS_SVH

// same-cycle implication
`define QMI_CHECK_SAME(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("qmi same-cycle check failed");

// next-cycle implication
`define QMI_CHECK_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("qmi next-cycle check failed");

`endif

[rtl/qmi_pkg.sv]
// shared types, constants and helper functions for the queue with middle insert
package qmi_pkg;

   localparam int CAPACITY    = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int IO_W        = 32;
   localparam int HALF_DEPTH  = (CAPACITY + 1) / 2;
   localparam int IDX_W       = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
   localparam int CNT_W       = $clog2(HALF_DEPTH + 1);
   localparam int TOT_W       = $clog2(CAPACITY + 1);
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = 1;
   localparam int CMDQ_CNT_W  = 2;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;

   // one classified operation for the execution side
   typedef struct packed {
      logic       front_wr_en;
      logic       back_wr_en;
      logic       move;
      logic       bypass;
      logic       pop;
      logic       respond;
      status_type status;
      idx_type    front_rd_addr;
      idx_type    front_wr_addr;
      idx_type    back_rd_addr;
      idx_type    back_wr_addr;
      value_type  data;
   } cmd_type;

   function automatic idx_type next_slot(input idx_type i);
      idx_type r;
      r = (i == IDX_W'(HALF_DEPTH - 1)) ? '0 : i + IDX_W'(1);
      return r;
   endfunction

   function automatic idx_type prev_slot(input idx_type i);
      idx_type r;
      r = (i == '0) ? IDX_W'(HALF_DEPTH - 1) : i - IDX_W'(1);
      return r;
   endfunction

   function automatic value_type to_value(input logic [IO_W-1:0] d);
      logic [VALUE_WIDTH+IO_W-1:0] wide;
      wide = {{VALUE_WIDTH{1'b0}}, d};
      return wide[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [IO_W-1:0] from_value(input value_type v);
      logic [VALUE_WIDTH+IO_W-1:0] wide;
      wide = {{IO_W{v[VALUE_WIDTH-1]}}, v};
      return wide[IO_W-1:0];
   endfunction

endpackage

[rtl/qmi_if.sv]
// request and response channel interfaces
interface qmi_req_if import qmi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             operation;
   logic signed [IO_W-1:0] data_in;

   modport source (output valid, output operation, output data_in, input ready);
   modport sink (input valid, input operation, input data_in, output ready);
endinterface

interface qmi_rsp_if import qmi_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [IO_W-1:0] data_out;
   logic [1:0]             status;

   modport source (output valid, output data_out, output status, input ready);
   modport sink (input valid, input data_out, input status, output ready);
endinterface

[rtl/qmi_front.sv]
// front side: accepts requests, tracks both halves and issues commands
module qmi_front import qmi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   qmi_req_if.sink  req,
   output logic     cmd_push,
   output cmd_type  cmd_data,
   input  logic     cmd_full
);

   idx_type            front_rd_ff, front_rd_in;
   idx_type            front_wr_ff, front_wr_in;
   idx_type            back_rd_ff, back_rd_in;
   idx_type            back_wr_ff, back_wr_in;
   logic [CNT_W-1:0]   front_cnt_ff, front_cnt_in;
   logic [CNT_W-1:0]   back_cnt_ff, back_cnt_in;
   logic [TOT_W-1:0]   total;
   logic               transfer;

   assign req.ready = !cmd_full;
   assign transfer  = req.valid && !cmd_full;
   assign total     = TOT_W'(front_cnt_ff) + TOT_W'(back_cnt_ff);

   always_comb begin
      front_rd_in  = front_rd_ff;
      front_wr_in  = front_wr_ff;
      back_rd_in   = back_rd_ff;
      back_wr_in   = back_wr_ff;
      front_cnt_in = front_cnt_ff;
      back_cnt_in  = back_cnt_ff;
      cmd_push     = 1'b0;
      cmd_data               = '0;
      cmd_data.status        = STATUS_OK;
      cmd_data.front_rd_addr = front_rd_ff;
      cmd_data.front_wr_addr = front_wr_ff;
      cmd_data.back_rd_addr  = back_rd_ff;
      cmd_data.back_wr_addr  = back_wr_ff;
      cmd_data.data          = to_value(req.data_in);
      case (req.operation)
         OP_PUSH: begin
            cmd_push = transfer;
            if (total >= TOT_W'(CAPACITY)) begin
               cmd_data.respond = 1'b1;
               cmd_data.status  = STATUS_FULL;
            end else begin
               cmd_data.back_wr_en = 1'b1;
               back_wr_in          = next_slot(back_wr_ff);
               if (front_cnt_ff == back_cnt_ff) begin
                  // tail push spills the back head into the front half
                  cmd_data.move   = 1'b1;
                  cmd_data.bypass = (back_cnt_ff == '0);
                  back_rd_in      = next_slot(back_rd_ff);
                  front_wr_in     = next_slot(front_wr_ff);
                  front_cnt_in    = front_cnt_ff + CNT_W'(1);
               end else begin
                  back_cnt_in = back_cnt_ff + CNT_W'(1);
               end
            end
         end
         OP_INSERT: begin
            cmd_push = transfer;
            if (total >= TOT_W'(CAPACITY)) begin
               cmd_data.respond = 1'b1;
               cmd_data.status  = STATUS_FULL;
            end else if (front_cnt_ff > back_cnt_ff) begin
               cmd_data.back_wr_en   = 1'b1;
               cmd_data.back_wr_addr = prev_slot(back_rd_ff);
               back_rd_in            = prev_slot(back_rd_ff);
               back_cnt_in           = back_cnt_ff + CNT_W'(1);
            end else begin
               cmd_data.front_wr_en = 1'b1;
               front_wr_in          = next_slot(front_wr_ff);
               front_cnt_in         = front_cnt_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            cmd_push         = transfer;
            cmd_data.respond = 1'b1;
            if (front_cnt_ff == '0) begin
               cmd_data.status = STATUS_EMPTY;
            end else begin
               cmd_data.pop = 1'b1;
               front_rd_in  = next_slot(front_rd_ff);
               if (back_cnt_ff == front_cnt_ff) begin
                  // refill front tail from back head
                  cmd_data.move = 1'b1;
                  back_rd_in    = next_slot(back_rd_ff);
                  front_wr_in   = next_slot(front_wr_ff);
                  back_cnt_in   = back_cnt_ff - CNT_W'(1);
               end else begin
                  front_cnt_in = front_cnt_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_rd_ff  <= '0;
         front_wr_ff  <= '0;
         back_rd_ff   <= '0;
         back_wr_ff   <= '0;
         front_cnt_ff <= '0;
         back_cnt_ff  <= '0;
      end else if (transfer) begin
         front_rd_ff  <= front_rd_in;
         front_wr_ff  <= front_wr_in;
         back_rd_ff   <= back_rd_in;
         back_wr_ff   <= back_wr_in;
         front_cnt_ff <= front_cnt_in;
         back_cnt_ff  <= back_cnt_in;
      end
   end

endmodule

[rtl/qmi_cmd_fifo.sv]
// two-entry command queue between front and back
module qmi_cmd_fifo import qmi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff;
   logic [CMDQ_CNT_W-1:0]  count_ff;

   assign full     = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + CMDQ_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMDQ_PTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + CMDQ_CNT_W'(1);
            2'b01:   count_ff <= count_ff - CMDQ_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[rtl/qmi_back.sv]
// back side: both half stores, command execution and response register
module qmi_back import qmi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd_data,
   input  logic      cmd_empty,
   output logic      cmd_pop,
   qmi_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      S_FETCH  = 2'b01,
      S_FINISH = 2'b10
   } back_state_type;

   back_state_type   state_ff, state_in;
   cmd_type          cur_ff;
   value_type        front_mem [HALF_DEPTH];
   value_type        back_mem [HALF_DEPTH];
   value_type        front_rdata_ff;
   value_type        back_rdata_ff;
   logic             rsp_valid_ff;
   logic [IO_W-1:0]  rsp_data_ff;
   status_type       rsp_status_ff;
   logic             finish_go;
   logic             front_we;
   idx_type          front_waddr;
   value_type        front_wdata;

   assign cmd_pop   = (state_ff == S_FETCH) && !cmd_empty;
   assign finish_go = (state_ff == S_FINISH) &&
                      (!cur_ff.respond || !rsp_valid_ff || rsp.ready);

   always_comb begin
      case (state_ff)
         S_FETCH:  state_in = cmd_pop ? S_FINISH : S_FETCH;
         S_FINISH: state_in = finish_go ? S_FETCH : S_FINISH;
         default:  state_in = S_FETCH;
      endcase
   end

   // front half single write port: insert on fetch, refill on finish
   always_comb begin
      front_we    = (cmd_pop && cmd_data.front_wr_en) || (finish_go && cur_ff.move);
      front_waddr = cmd_pop ? cmd_data.front_wr_addr : cur_ff.front_wr_addr;
      if (cmd_pop) begin
         front_wdata = cmd_data.data;
      end else begin
         front_wdata = cur_ff.bypass ? cur_ff.data : back_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_we) begin
         front_mem[front_waddr] <= front_wdata;
      end
      if (cmd_pop) begin
         front_rdata_ff <= front_mem[cmd_data.front_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.back_wr_en) begin
         back_mem[cmd_data.back_wr_addr] <= cmd_data.data;
      end
      if (cmd_pop) begin
         back_rdata_ff <= back_mem[cmd_data.back_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cur_ff <= cmd_data;
      end
      if (finish_go && cur_ff.respond) begin
         rsp_data_ff   <= cur_ff.pop ? from_value(front_rdata_ff) : '0;
         rsp_status_ff <= cur_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FETCH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish_go && cur_ff.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_out = rsp_data_ff;
   assign rsp.status   = rsp_status_ff;

endmodule

[rtl/queue_with_middle_insert_core.sv]
// top level of the bounded queue with push, middle insert and pop
//
//   channel   dir   payload                       transfer
//   req_chan  in    operation[1:0], data_in[31:0]  valid & ready
//   rsp_chan  out   data_out[31:0], status[1:0]    valid & ready
//
// in the back end the fetch state reads the heads and writes the new value, and
// the finish state writes the refilled front tail on the front half's single
// write port; a new command is fetched only after the finish state is done
// requests enter a 2-deep command queue, so the front accepts while results wait
// a stalled response holds the back end, the queue then fills and ready drops
// synchronous reset clears pointers, counts, back-end state and response valid only, no clearing pass
`include "queue_with_middle_insert_core_macros.svh"

module queue_with_middle_insert_core import qmi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qmi_req_if.sink   req_chan,
   qmi_rsp_if.source rsp_chan
);

   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_in_data;
   cmd_type cmd_out_data;

   qmi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   qmi_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   qmi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_out_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_chan)
   );

   `QMI_CHECK_SAME(a_no_push_when_full, clock, reset, cmd_push, !cmd_full)
   `QMI_CHECK_SAME(a_no_pop_when_empty, clock, reset, cmd_pop, !cmd_empty)
   `QMI_CHECK_NEXT(a_pop_spacing, clock, reset, cmd_pop, !cmd_pop)

endmodule
